// File: hw/rtl/kwm_pkg.sv
// Shared constants and types for the k-way merge block.
`timescale 1ns / 1ps
package kwm_pkg;

   localparam int RUNS_MAX  = 8;
   localparam int RUN_DEPTH = 1024;

   localparam int VALUE_W  = 32;
   localparam int RUN_ID_W = 3;
   localparam int CFG_W    = 4;
   localparam int CMD_W    = 1;

   localparam int RUN_W  = (RUNS_MAX > 1) ? $clog2(RUNS_MAX) : 1;
   localparam int CNT_W  = $clog2(RUNS_MAX + 1);
   localparam int FILL_W = $clog2(RUN_DEPTH + 1);
   localparam int ADDR_W = $clog2(RUNS_MAX * RUN_DEPTH);

   localparam logic [CMD_W-1:0] CMD_LOAD = 1'b0;
   localparam logic [CMD_W-1:0] CMD_POP  = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   // Control from the sequencer to the compare unit.
   typedef struct packed {
      logic              clear;
      logic              cmp_en;
      logic [RUN_W-1:0]  run;
      logic [FILL_W-1:0] left;
   } scan_ctl_type;

   // Running result of the compare unit.
   typedef struct packed {
      logic               found;
      logic               single;
      logic [RUN_W-1:0]   run;
      logic [VALUE_W-1:0] value;
   } scan_res_type;

endpackage

// File: hw/rtl/k_way_merge.sv
// Top level of the k-way merge: sequencer, run counters and result register.
//
// Usage:
//   Command channel: drive req_command, req_run_id, req_value with start high;
//   the command transfers at a rising edge where start is high and busy low.
//   A load (command 0) appends req_value to run req_run_id and completes in
//   the transfer cycle itself, so busy stays low and a new command may follow
//   on the next cycle. The first load after any pop starts a new batch.
//   A pop (command 1) raises busy while the sequencer walks the active runs,
//   one run head per cycle through the element store read port and a single
//   shared comparator; min(run_count, 8) runs are active. The result strobe
//   rsp_strobe rises for one cycle only after the last head is compared,
//   and busy falls in that same cycle.
//   The receiver cannot stall: each result transfers at the edge that ends
//   its strobe cycle. Loads produce no result.
//   Configuration: csr_wdata writes run_count when csr_valid is high; csr_ready
//   is always high. Write it only while no pop is in flight.
//   Reset (synchronous, active high) clears all fill counts and read indexes,
//   sets run_count to 1 and returns to idle. Store contents are not cleared.
`timescale 1ns / 1ps
module k_way_merge (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [kwm_pkg::CMD_W-1:0]    req_command,
   input  logic [kwm_pkg::RUN_ID_W-1:0] req_run_id,
   input  logic [kwm_pkg::VALUE_W-1:0]  req_value,
   output logic                         rsp_strobe,
   output logic [kwm_pkg::VALUE_W-1:0]  rsp_merged_value,
   output logic                         rsp_last_of_merge,
   output logic                         rsp_exhausted,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [kwm_pkg::CFG_W-1:0]    csr_wdata
);
   import kwm_pkg::*;

   state_type state_ff, state_in;

   logic [CFG_W-1:0]  run_count_ff, run_count_in;
   logic [CNT_W-1:0]  nruns_ff, nruns_in;
   logic [CNT_W-1:0]  scan_ff, scan_in;
   logic              pend_ff, pend_in;
   logic [RUN_W-1:0]  pend_run_ff, pend_run_in;
   logic [FILL_W-1:0] pend_left_ff, pend_left_in;
   logic              started_ff, started_in;
   logic [FILL_W-1:0] fill_ff [RUNS_MAX];
   logic [FILL_W-1:0] fill_in [RUNS_MAX];
   logic [FILL_W-1:0] rdx_ff  [RUNS_MAX];
   logic [FILL_W-1:0] rdx_in  [RUNS_MAX];

   logic               strobe_ff, strobe_in;
   logic [VALUE_W-1:0] value_ff, value_in;
   logic               last_ff, last_in;
   logic               exh_ff, exh_in;

   logic               accept, accept_load, accept_pop, load_ok;
   logic [RUN_W-1:0]   sel;
   logic [FILL_W-1:0]  fill_sel, rdx_sel, wr_slot;
   logic               issue;
   logic               wr_en;
   logic [ADDR_W-1:0]  wr_addr, rd_addr;
   logic [VALUE_W-1:0] rd_data;
   scan_ctl_type       ctl;
   scan_res_type       res;

   assign accept      = start && !busy;
   assign accept_load = accept && (req_command == CMD_LOAD);
   assign accept_pop  = accept && (req_command == CMD_POP);
   assign load_ok     = (int'(req_run_id) < RUNS_MAX);

   // Pick the one run whose counters are looked at this cycle.
   always_comb begin
      case (state_ff)
         ST_IDLE: sel = RUN_W'(req_run_id);
         ST_SCAN: sel = RUN_W'(scan_ff);
         ST_DONE: sel = res.run;
         default: sel = '0;
      endcase
      fill_sel = fill_ff[sel];
      rdx_sel  = rdx_ff[sel];
   end

   // A new batch writes slot zero; otherwise append at the fill count.
   assign wr_slot = started_ff ? '0 : fill_sel;
   assign wr_en   = accept_load && load_ok && (started_ff || (fill_sel < FILL_W'(RUN_DEPTH)));
   assign wr_addr = ADDR_W'(sel) * ADDR_W'(RUN_DEPTH) + ADDR_W'(wr_slot);
   assign rd_addr = ADDR_W'(sel) * ADDR_W'(RUN_DEPTH) + ADDR_W'(rdx_sel);

   assign issue = (state_ff == ST_SCAN) && (scan_ff < nruns_ff);

   kwm_store u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_value),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // The comparator sees the head read in the previous cycle.
   assign ctl.clear  = accept_pop;
   assign ctl.cmp_en = pend_ff;
   assign ctl.run    = pend_run_ff;
   assign ctl.left   = pend_left_ff;

   kwm_scan_unit u_scan (
      .clock (clock),
      .reset (reset),
      .ctl   (ctl),
      .head  (rd_data),
      .res   (res)
   );

   always_comb begin
      state_in     = state_ff;
      run_count_in = run_count_ff;
      nruns_in     = nruns_ff;
      scan_in      = scan_ff;
      pend_in      = 1'b0;
      pend_run_in  = sel;
      pend_left_in = fill_sel - rdx_sel;
      started_in   = started_ff;
      fill_in      = fill_ff;
      rdx_in       = rdx_ff;
      strobe_in    = 1'b0;
      value_in     = value_ff;
      last_in      = last_ff;
      exh_in       = exh_ff;

      if (csr_valid) begin
         run_count_in = csr_wdata;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept_load) begin
               // drop all counts when a pop came before this load
               if (started_ff) begin
                  for (int r = 0; r < RUNS_MAX; r++) begin
                     fill_in[r] = '0;
                     rdx_in[r]  = '0;
                  end
               end
               started_in = 1'b0;
               if (wr_en) begin
                  fill_in[sel] = wr_slot + FILL_W'(1);
               end
            end else if (accept_pop) begin
               started_in = 1'b1;
               nruns_in   = (int'(run_count_ff) > RUNS_MAX) ? CNT_W'(RUNS_MAX)
                                                            : CNT_W'(run_count_ff);
               scan_in    = '0;
               state_in   = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (issue) begin
               // skip consumed runs: the read still goes out, compare is off
               pend_in = (rdx_sel < fill_sel);
               scan_in = scan_ff + CNT_W'(1);
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (res.found) begin
               rdx_in[sel] = rdx_sel + FILL_W'(1);
            end
            strobe_in = 1'b1;
            value_in  = res.found ? res.value : '0;
            last_in   = res.found && res.single;
            exh_in    = !res.found;
            state_in  = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         run_count_ff <= CFG_W'(1);
         started_ff   <= 1'b0;
         pend_ff      <= 1'b0;
         strobe_ff    <= 1'b0;
         scan_ff      <= '0;
         nruns_ff     <= '0;
         for (int r = 0; r < RUNS_MAX; r++) begin
            fill_ff[r] <= '0;
            rdx_ff[r]  <= '0;
         end
      end else begin
         state_ff     <= state_in;
         run_count_ff <= run_count_in;
         started_ff   <= started_in;
         pend_ff      <= pend_in;
         strobe_ff    <= strobe_in;
         scan_ff      <= scan_in;
         nruns_ff     <= nruns_in;
         fill_ff      <= fill_in;
         rdx_ff       <= rdx_in;
      end
      pend_run_ff  <= pend_run_in;
      pend_left_ff <= pend_left_in;
      value_ff     <= value_in;
      last_ff      <= last_in;
      exh_ff       <= exh_in;
   end

   assign busy              = (state_ff != ST_IDLE);
   assign csr_ready         = 1'b1;
   assign rsp_strobe        = strobe_ff;
   assign rsp_merged_value  = value_ff;
   assign rsp_last_of_merge = last_ff;
   assign rsp_exhausted     = exh_ff;

endmodule

// File: hw/rtl/kwm_store.sv
// Element store: one write port, one registered read port.
`timescale 1ns / 1ps
module kwm_store (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [kwm_pkg::ADDR_W-1:0]  wr_addr,
   input  logic [kwm_pkg::VALUE_W-1:0] wr_data,
   input  logic [kwm_pkg::ADDR_W-1:0]  rd_addr,
   output logic [kwm_pkg::VALUE_W-1:0] rd_data
);
   import kwm_pkg::*;

   logic [VALUE_W-1:0] mem [RUNS_MAX * RUN_DEPTH];
   logic [VALUE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/kwm_scan_unit.sv
// Shared compare unit: keeps the smallest signed head seen and the remaining count, saturated at two.
`timescale 1ns / 1ps
module kwm_scan_unit (
   input  logic                        clock,
   input  logic                        reset,
   input  kwm_pkg::scan_ctl_type       ctl,
   input  logic [kwm_pkg::VALUE_W-1:0] head,
   output kwm_pkg::scan_res_type       res
);
   import kwm_pkg::*;

   logic               found_ff, found_in;
   logic [1:0]         rem_ff, rem_in;
   logic [RUN_W-1:0]   run_ff, run_in;
   logic [VALUE_W-1:0] value_ff, value_in;
   logic [1:0]         left_sat;
   logic [2:0]         rem_sum;
   logic               better;

   always_comb begin
      left_sat = (ctl.left >= FILL_W'(2)) ? 2'd2 : ctl.left[1:0];
      rem_sum  = {1'b0, rem_ff} + {1'b0, left_sat};
      better   = !found_ff || ($signed(head) < $signed(value_ff));
      found_in = found_ff;
      rem_in   = rem_ff;
      run_in   = run_ff;
      value_in = value_ff;
      if (ctl.clear) begin
         found_in = 1'b0;
         rem_in   = 2'd0;
      end else if (ctl.cmp_en) begin
         // saturate at two: only "exactly one left" matters
         rem_in = (rem_sum >= 3'd2) ? 2'd2 : rem_sum[1:0];
         if (better) begin
            found_in = 1'b1;
            run_in   = ctl.run;
            value_in = head;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
         rem_ff   <= 2'd0;
      end else begin
         found_ff <= found_in;
         rem_ff   <= rem_in;
      end
      run_ff   <= run_in;
      value_ff <= value_in;
   end

   assign res.found  = found_ff;
   assign res.single = (rem_ff == 2'd1);
   assign res.run    = run_ff;
   assign res.value  = value_ff;

endmodule

// File: hw/rtl/kwm_checker.sv
// Port-level checks for the k-way merge, bound to the top level.
`timescale 1ns / 1ps
module kwm_port_checks (
   input logic                         clock,
   input logic                         reset,
   input logic                         start,
   input logic                         busy,
   input logic [kwm_pkg::CMD_W-1:0]    req_command,
   input logic                         rsp_strobe,
   input logic [kwm_pkg::VALUE_W-1:0]  rsp_merged_value,
   input logic                         rsp_last_of_merge,
   input logic                         rsp_exhausted
);
   import kwm_pkg::*;

   // A pop holds the block busy on the next cycle.
   a_pop_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_command == CMD_POP)) |=> busy)
      else $error("pop transfer did not raise busy");

   // A load completes in its transfer cycle.
   a_load_quick: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_command == CMD_LOAD)) |=> !busy)
      else $error("load transfer raised busy");

   // A result only ends a pop, and busy drops with it.
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> ($past(busy) && !busy))
      else $error("result strobe without a pop in flight");

   // An exhausted result carries zero and no last mark.
   a_exh_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_exhausted) |-> ((rsp_merged_value == '0) && !rsp_last_of_merge))
      else $error("exhausted result with data");

endmodule

bind k_way_merge kwm_port_checks u_kwm_port_checks (
   .clock             (clock),
   .reset             (reset),
   .start             (start),
   .busy              (busy),
   .req_command       (req_command),
   .rsp_strobe        (rsp_strobe),
   .rsp_merged_value  (rsp_merged_value),
   .rsp_last_of_merge (rsp_last_of_merge),
   .rsp_exhausted     (rsp_exhausted)
);
